[sv/extent_block_map_lookup_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the extent block map lookup unit
// Concurrent assertion wrappers. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXTENT_BLOCK_MAP_LOOKUP_UNIT_ASSERT_SVH
`define EXTENT_BLOCK_MAP_LOOKUP_UNIT_ASSERT_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/ebml_pkg.sv]
// ----------------------------------------------------------------------------
// ebml_pkg
// Shared sizes, types and codes of the extent block map lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebml_pkg;

  localparam int TREE_ENTRIES = 512;
  localparam int INLINE_SLOTS = 4;
  localparam int BLOCK_BYTES  = 4096;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 9;
  localparam int START_W = 20;
  localparam int PHYS_W  = 32;
  localparam int LEN_W   = 16;
  localparam int BOFF_W  = 32;
  localparam int DEV_W   = 8;
  localparam int OIB_W   = 12;
  localparam int BIB_W   = 13;

  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int LB_W      = BOFF_W - BLK_SHIFT;
  localparam int BB_W      = BLK_SHIFT + 1;
  localparam int CMP_W     = ((LB_W > START_W) ? LB_W : START_W) + 1;
  localparam int DLT_W     = CMP_W - 1;
  localparam int TREE_AW   = (TREE_ENTRIES > 1) ? $clog2(TREE_ENTRIES) : 1;
  localparam int INL_AW    = (INLINE_SLOTS > 1) ? $clog2(INLINE_SLOTS) : 1;

  typedef logic [LB_W-1:0]      ebml_lb_t;
  typedef logic [BLK_SHIFT-1:0] ebml_within_t;
  typedef logic [BB_W-1:0]      ebml_bb_t;
  typedef logic [CMP_W-1:0]     ebml_cmp_t;
  typedef logic [DLT_W-1:0]     ebml_dlt_t;
  typedef logic [TREE_AW-1:0]   ebml_taddr_t;
  typedef logic [INL_AW-1:0]    ebml_iidx_t;
  typedef logic [OIB_W-1:0]     ebml_oib_t;
  typedef logic [BIB_W-1:0]     ebml_bib_t;
  typedef logic [PHYS_W-1:0]    ebml_phys_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [PHYS_W-1:0]  phys;
    logic [LEN_W-1:0]   len;
    logic               hole;
  } ebml_ext_t;

  typedef struct packed {
    logic              hit;
    logic [PHYS_W-1:0] blk;
  } ebml_match_t;

  typedef enum logic [OP_W-1:0] {
    OP_WR_INLINE = 2'd0,
    OP_WR_TREE   = 2'd1,
    OP_LOOKUP    = 2'd2
  } ebml_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INLINE,
    ST_TREE,
    ST_DONE
  } ebml_state_e;

endpackage

`default_nettype wire

[sv/ebml_ram.sv]
// ----------------------------------------------------------------------------
// ebml_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/ebml_match.sv]
// ----------------------------------------------------------------------------
// ebml_match
// Shared extent compare unit: coverage test and physical block translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebml_match (
  input  wire ebml_pkg::ebml_ext_t   ext_i,
  input  wire ebml_pkg::ebml_lb_t    lb_i,
  output ebml_pkg::ebml_match_t      res_o
);

  ebml_pkg::ebml_cmp_t diff;
  ebml_pkg::ebml_dlt_t delta;
  logic                ge;
  logic                in_len;

  always_comb begin
    diff   = ebml_pkg::ebml_cmp_t'(lb_i) - ebml_pkg::ebml_cmp_t'(ext_i.start);
    ge     = ~diff[ebml_pkg::CMP_W-1];
    delta  = diff[ebml_pkg::DLT_W-1:0];
    in_len = delta < ebml_pkg::ebml_dlt_t'(ext_i.len);
    res_o.hit = (ext_i.len != '0) && ge && in_len;
    res_o.blk = ext_i.hole ? '0 : ext_i.phys + ebml_pkg::ebml_phys_t'(delta);
  end

endmodule

`default_nettype wire

[sv/extent_block_map_lookup_unit.sv]
// ----------------------------------------------------------------------------
// extent_block_map_lookup_unit
// Translates file byte offsets through inline extents and an overflow table.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   operation, slot, extent, offset
//  out      output     out_valid_o / out_stall_i block, offsets, mapped, device
//
//  A lookup passes k inline slots (at most 4) and then n table entries
//  (at most 512) through the shared compare unit, one per cycle; the
//  table entries are fed by the table RAM read port.
//  After reset a clearing pass zeroes all 512 table entries; in_stall_o
//  stays high until it ends. One transaction is in work at a time; the
//  output register frees the unit once the result is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "extent_block_map_lookup_unit_assert.svh"

module extent_block_map_lookup_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [8:0]  slot_index_i,
  input  wire logic [19:0] ext_start_i,
  input  wire logic [31:0] ext_phys_i,
  input  wire logic [15:0] ext_length_i,
  input  wire logic        ext_hole_i,
  input  wire logic [31:0] byte_offset_i,
  input  wire logic [7:0]  device_i,
  input  wire logic        tree_present_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      block_number_o,
  output logic [11:0]      offset_in_block_o,
  output logic [12:0]      bytes_in_block_o,
  output logic             mapped_o,
  output logic [7:0]       device_out_o
);

  ebml_pkg::ebml_state_e  state_q, state_d;
  ebml_pkg::ebml_taddr_t  clr_q, clr_d;
  ebml_pkg::ebml_taddr_t  ptr_q, ptr_d;
  ebml_pkg::ebml_iidx_t   idx_q, idx_d;
  ebml_pkg::ebml_phys_t   res_blk_q, res_blk_d;
  ebml_pkg::ebml_lb_t     lb_q;
  ebml_pkg::ebml_within_t within_q;
  logic [7:0]             dev_q;
  logic                   tree_q;
  logic                   lookup_q;

  ebml_pkg::ebml_ext_t    inl_q [ebml_pkg::INLINE_SLOTS];
  logic                   inl_we;

  logic                   ram_we;
  ebml_pkg::ebml_taddr_t  ram_waddr;
  ebml_pkg::ebml_ext_t    ram_wdata;
  ebml_pkg::ebml_taddr_t  ram_raddr;
  ebml_pkg::ebml_ext_t    ram_rdata;

  ebml_pkg::ebml_ext_t    cmp_ext;
  ebml_pkg::ebml_match_t  cmp_res;

  logic                   accept;
  logic                   load_out;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            block_number_q;
  logic [11:0]            offset_in_block_q;
  logic [12:0]            bytes_in_block_q;
  logic                   mapped_q;
  logic [7:0]             device_out_q;
  ebml_pkg::ebml_ext_t    wr_ext;

  assign accept     = in_valid_i && (state_q == ebml_pkg::ST_IDLE);
  assign in_stall_o = (state_q != ebml_pkg::ST_IDLE);

  assign wr_ext.start = ext_start_i;
  assign wr_ext.phys  = ext_phys_i;
  assign wr_ext.len   = ext_length_i;
  assign wr_ext.hole  = ext_hole_i;

  ebml_ram #(
    .WIDTH($bits(ebml_pkg::ebml_ext_t)),
    .DEPTH(ebml_pkg::TREE_ENTRIES)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ebml_match u_match (
    .ext_i(cmp_ext),
    .lb_i (lb_q),
    .res_o(cmp_res)
  );

  always_comb begin
    cmp_ext = (state_q == ebml_pkg::ST_TREE) ? ram_rdata : inl_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ebml_pkg::ST_CLEAR;
      clr_q       <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      res_blk_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      res_blk_q   <= res_blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ebml_pkg::INLINE_SLOTS; i++) begin
        inl_q[i] <= '0;
      end
    end else if (inl_we) begin
      inl_q[slot_index_i[ebml_pkg::INL_AW-1:0]] <= wr_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lb_q     <= byte_offset_i[31:ebml_pkg::BLK_SHIFT];
      within_q <= byte_offset_i[ebml_pkg::BLK_SHIFT-1:0];
      dev_q    <= device_i;
      tree_q   <= tree_present_i;
      lookup_q <= (ebml_pkg::ebml_op_e'(operation_i) == ebml_pkg::OP_LOOKUP);
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    res_blk_d = res_blk_q;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = '0;
    inl_we    = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ebml_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ebml_pkg::ebml_taddr_t'(ebml_pkg::TREE_ENTRIES - 1)) begin
          state_d = ebml_pkg::ST_IDLE;
        end
      end
      ebml_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_blk_d = '0;
          idx_d     = '0;
          ptr_d     = '0;
          case (ebml_pkg::ebml_op_e'(operation_i))
            ebml_pkg::OP_WR_INLINE: begin
              inl_we  = (int'(slot_index_i) < ebml_pkg::INLINE_SLOTS);
              state_d = ebml_pkg::ST_DONE;
            end
            ebml_pkg::OP_WR_TREE: begin
              ram_we    = (int'(slot_index_i) < ebml_pkg::TREE_ENTRIES);
              ram_waddr = ebml_pkg::ebml_taddr_t'(slot_index_i);
              ram_wdata = wr_ext;
              state_d   = ebml_pkg::ST_DONE;
            end
            ebml_pkg::OP_LOOKUP: begin
              state_d = ebml_pkg::ST_INLINE;
            end
            default: begin
              state_d = ebml_pkg::ST_DONE;
            end
          endcase
        end
      end
      ebml_pkg::ST_INLINE: begin
        if (cmp_res.hit) begin
          res_blk_d = cmp_res.blk;
          state_d   = ebml_pkg::ST_DONE;
        end else if (idx_q == ebml_pkg::ebml_iidx_t'(ebml_pkg::INLINE_SLOTS - 1)) begin
          state_d = tree_q ? ebml_pkg::ST_TREE : ebml_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ebml_pkg::ST_TREE: begin
        ram_raddr = ptr_q + 1'b1;
        ptr_d     = ptr_q + 1'b1;
        if (ram_rdata.len == '0) begin
          state_d = ebml_pkg::ST_DONE;
        end else if (cmp_res.hit) begin
          res_blk_d = cmp_res.blk;
          state_d   = ebml_pkg::ST_DONE;
        end else if (ptr_q == ebml_pkg::ebml_taddr_t'(ebml_pkg::TREE_ENTRIES - 1)) begin
          state_d = ebml_pkg::ST_DONE;
        end
      end
      ebml_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ebml_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ebml_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      block_number_q    <= res_blk_q;
      mapped_q          <= (res_blk_q != '0);
      offset_in_block_q <= lookup_q ? ebml_pkg::ebml_oib_t'(within_q) : '0;
      bytes_in_block_q  <= lookup_q ?
          ebml_pkg::ebml_bib_t'(ebml_pkg::ebml_bb_t'(ebml_pkg::BLOCK_BYTES) -
                                ebml_pkg::ebml_bb_t'(within_q)) : '0;
      device_out_q      <= lookup_q ? dev_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign block_number_o    = block_number_q;
  assign offset_in_block_o = offset_in_block_q;
  assign bytes_in_block_o  = bytes_in_block_q;
  assign mapped_o          = mapped_q;
  assign device_out_o      = device_out_q;

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, in_stall_o, "Unit took a second transaction while busy.")
  `ASSERT_IMPLY(a_mapped_nonzero, clk_i, rst_ni, out_valid_o, mapped_o == (block_number_o != '0), "Mapped flag disagrees with block number.")
  `ASSERT_NEXT(a_scan_ends, clk_i, rst_ni, (state_q == ebml_pkg::ST_TREE) && (ptr_q == ebml_pkg::ebml_taddr_t'(ebml_pkg::TREE_ENTRIES - 1)), state_q == ebml_pkg::ST_DONE, "Table scan ran past the last entry.")

endmodule

`default_nettype wire
